// ===== rtl/rccn_pkg.sv =====
// ----------------------------------------------------------------------------
// rccn_pkg
// shared widths, register codes and control structs of the rc channel
// calibrate and normalize block
// ----------------------------------------------------------------------------
package rccn_pkg;

  localparam int WidthBits   = 16;
  localparam int FracBits    = 16;
  localparam int PosBits     = FracBits + 1;
  localparam int NumCh       = 4;
  localparam int ChBits      = $clog2(NumCh);
  localparam int StepBits    = $clog2(FracBits);
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 16;
  localparam int MinValidBits = 16;

  localparam logic [MinValidBits-1:0] ValidReset = MinValidBits'(100);
  localparam logic [PosBits-1:0]      OneQ       = {1'b1, {FracBits{1'b0}}};

  typedef enum logic [CfgIdxBits-1:0] {
    REG_CAL_EN    = 2'd0,
    REG_MIN_VALID = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                 start;
    logic [WidthBits-1:0] numer;
    logic [WidthBits-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [FracBits-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/rccn_if.sv =====
// ----------------------------------------------------------------------------
// rccn_if
// valid/ready channels of the rc channel calibrate and normalize block
// ----------------------------------------------------------------------------
interface rccn_in_if;
  import rccn_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WidthBits-1:0] width_ch1;
  logic [WidthBits-1:0] width_ch2;
  logic [WidthBits-1:0] width_ch3;
  logic [WidthBits-1:0] width_ch4;

  modport source (output valid, width_ch1, width_ch2, width_ch3, width_ch4, input ready);
  modport sink (input valid, width_ch1, width_ch2, width_ch3, width_ch4, output ready);
endinterface

interface rccn_out_if;
  import rccn_pkg::*;
  logic               valid;
  logic               ready;
  logic [PosBits-1:0] position_ch1;
  logic [PosBits-1:0] position_ch2;
  logic [PosBits-1:0] position_ch3;
  logic [PosBits-1:0] position_ch4;

  modport source (output valid, position_ch1, position_ch2, position_ch3, position_ch4,
                  input ready);
  modport sink (input valid, position_ch1, position_ch2, position_ch3, position_ch4,
                output ready);
endinterface

interface rccn_cfg_if;
  import rccn_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/rccn_div.sv =====
// ----------------------------------------------------------------------------
// rccn_div
// restoring divider, one quotient bit per cycle, numerator below denominator
// ----------------------------------------------------------------------------
module rccn_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rccn_pkg::div_req_t req_i,
  output rccn_pkg::div_rsp_t rsp_o
);
  import rccn_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [StepBits-1:0]  cnt_q;
  logic [WidthBits-1:0] rem_q;
  logic [WidthBits-1:0] den_q;
  logic [FracBits-1:0]  quot_q;

  logic [WidthBits:0] shifted;
  logic [WidthBits:0] diff;
  logic               ge;

  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= StepBits'(FracBits - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - StepBits'(1);
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.numer;
      den_q  <= req_i.denom;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[WidthBits-1:0] : shifted[WidthBits-1:0];
      quot_q <= {quot_q[FracBits-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== rtl/rc_channel_calibrate_normalize.sv =====
// ----------------------------------------------------------------------------
// rc_channel_calibrate_normalize
// per-channel min/max calibration and normalization of four rc pulse widths
// ----------------------------------------------------------------------------
// each channel passes the update and check states, and the wait state as well
//   when it needs the shared 16-step restoring divider
// a new frame is taken only in the idle state, once the previous one has gone
//   to the output register; a stalled output holds the input
// reset: bounds go to lower all ones and upper zero, calibration off,
//   min valid width 100; no clearing pass, ready right after reset
module rc_channel_calibrate_normalize (
  input  logic       clk_i,
  input  logic       rst_ni,
  rccn_cfg_if.sink   cfg_i,
  rccn_in_if.sink    in_i,
  rccn_out_if.source out_o
);
  import rccn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CHECK,
    ST_WAIT,
    ST_FLUSH
  } state_e;

  state_e state_q;
  logic [ChBits-1:0] ch_q;

  // configuration registers
  logic                    cal_en_q;
  logic [MinValidBits-1:0] min_valid_q;

  // per-channel calibration bounds
  logic [WidthBits-1:0] lo_q [NumCh];
  logic [WidthBits-1:0] hi_q [NumCh];

  // frame work registers
  logic [WidthBits-1:0] width_q [NumCh];
  logic [PosBits-1:0]   pos_q [NumCh];

  // output register
  logic               out_valid_q;
  logic [PosBits-1:0] out_pos_q [NumCh];

  // current channel view
  logic [WidthBits-1:0] w;
  logic [WidthBits-1:0] lo;
  logic [WidthBits-1:0] hi;
  logic                 cal_hit;
  logic [WidthBits-1:0] lo_new;
  logic [WidthBits-1:0] hi_new;
  logic                 is_zero;
  logic                 is_full;
  logic                 last_ch;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign w  = width_q[ch_q];
  assign lo = lo_q[ch_q];
  assign hi = hi_q[ch_q];

  // a width above the threshold widens the bounds while calibrating
  assign cal_hit = cal_en_q && (w > min_valid_q);
  assign lo_new  = (cal_hit && (w < lo)) ? w : lo;
  assign hi_new  = (cal_hit && (w > hi)) ? w : hi;

  // empty range or at/below lower bound gives zero, at/above upper gives one
  assign is_zero = (hi <= lo) || (w <= lo);
  assign is_full = (w >= hi);
  assign last_ch = (ch_q == ChBits'(NumCh - 1));

  // strictly inside the range: numerator is below the span, quotient fits
  assign div_req.start = (state_q == ST_CHECK) && !is_zero && !is_full;
  assign div_req.numer = w - lo;
  assign div_req.denom = hi - lo;

  rccn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);

  assign out_o.valid        = out_valid_q;
  assign out_o.position_ch1 = out_pos_q[0];
  assign out_o.position_ch2 = out_pos_q[1];
  assign out_o.position_ch3 = out_pos_q[2];
  assign out_o.position_ch4 = out_pos_q[3];

  // sequencer, configuration, bounds and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      cal_en_q    <= 1'b0;
      min_valid_q <= ValidReset;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NumCh; c++) begin
        lo_q[c] <= '1;
        hi_q[c] <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_CAL_EN:    cal_en_q    <= cfg_i.data[0];
          REG_MIN_VALID: min_valid_q <= cfg_i.data[MinValidBits-1:0];
          default: ;
        endcase
      end

      // load a finished frame, or free the register once it is taken
      if ((state_q == ST_FLUSH) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            ch_q    <= '0;
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          lo_q[ch_q] <= lo_new;
          hi_q[ch_q] <= hi_new;
          state_q    <= ST_CHECK;
        end
        ST_CHECK: begin
          if (is_zero || is_full) begin
            ch_q    <= ch_q + ChBits'(1);
            state_q <= last_ch ? ST_FLUSH : ST_UPDATE;
          end else begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (div_rsp.done) begin
            ch_q    <= ch_q + ChBits'(1);
            state_q <= last_ch ? ST_FLUSH : ST_UPDATE;
          end
        end
        ST_FLUSH: begin
          // hand the frame over once the output register is free
          if (!out_valid_q || out_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      width_q[0] <= in_i.width_ch1;
      width_q[1] <= in_i.width_ch2;
      width_q[2] <= in_i.width_ch3;
      width_q[3] <= in_i.width_ch4;
    end
    if (state_q == ST_CHECK) begin
      if (is_zero) begin
        pos_q[ch_q] <= '0;
      end else if (is_full) begin
        pos_q[ch_q] <= OneQ;
      end
    end
    if ((state_q == ST_WAIT) && div_rsp.done) begin
      pos_q[ch_q] <= PosBits'(div_rsp.quot);
    end
    if ((state_q == ST_FLUSH) && (!out_valid_q || out_o.ready)) begin
      for (int c = 0; c < NumCh; c++) begin
        out_pos_q[c] <= pos_q[c];
      end
    end
  end

  // a frame transaction makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("block still ready after taking a frame");

  // the divider only finishes while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_WAIT))
    else $error("divider finished outside wait state");

  // divisions start only strictly inside the range, so the quotient fits
  a_div_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (div_req.denom > div_req.numer) && !div_rsp.busy)
    else $error("division started out of range or while busy");

  // positions never exceed one
  a_pos_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_pos_q[0] <= OneQ) && (out_pos_q[1] <= OneQ)
                 && (out_pos_q[2] <= OneQ) && (out_pos_q[3] <= OneQ))
    else $error("position above one");

endmodule

// ===== sim/rc_channel_calibrate_normalize_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_channel_calibrate_normalize_checker
// watches the config, frame and position channels, keeps its own per-channel
// bounds and settings, predicts every frame's positions and compares them in
// order with what the block returns
// ----------------------------------------------------------------------------
module rc_channel_calibrate_normalize_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rccn_cfg_if  cfg_mon,
  rccn_in_if   in_mon,
  rccn_out_if  out_mon,
  input  logic end_of_test_i,
  output int   frames_checked_o,
  output int   fail_count_o
);
  import rccn_pkg::*;

  typedef logic [NumCh-1:0][WidthBits-1:0] frame_widths_t;
  typedef logic [NumCh-1:0][PosBits-1:0]   frame_positions_t;

  localparam int ProdBits = WidthBits + FracBits;

  logic                    cal_enabled;
  logic [MinValidBits-1:0] valid_floor;
  logic [WidthBits-1:0]    ch_lower [NumCh];
  logic [WidthBits-1:0]    ch_upper [NumCh];
  frame_positions_t        pending_positions [$];

  // position of w inside [lo, hi] as Q1.FracBits, clamped at both ends
  function automatic logic [PosBits-1:0] scale_to_range(logic [WidthBits-1:0] w,
                                                        logic [WidthBits-1:0] lo,
                                                        logic [WidthBits-1:0] hi);
    logic [WidthBits-1:0] offset;
    logic [ProdBits-1:0]  scaled;
    logic [ProdBits-1:0]  quot;
    if (hi <= lo) return '0;
    if (w <= lo) return '0;
    if (w >= hi) return OneQ;
    offset = w - lo;
    scaled = {offset, {FracBits{1'b0}}};
    quot   = scaled / ProdBits'(hi - lo);
    if (quot > ProdBits'(OneQ)) return OneQ;
    return quot[PosBits-1:0];
  endfunction

  // widen the bounds first when calibrating, then normalize every channel
  function automatic frame_positions_t calibrate_and_normalize(frame_widths_t w);
    frame_positions_t pos;
    for (int c = 0; c < NumCh; c++) begin
      if (cal_enabled && w[c] > valid_floor) begin
        if (w[c] < ch_lower[c]) ch_lower[c] = w[c];
        if (w[c] > ch_upper[c]) ch_upper[c] = w[c];
      end
      pos[c] = scale_to_range(w[c], ch_lower[c], ch_upper[c]);
    end
    return pos;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    frame_positions_t want;
    frame_positions_t got;
    if (!rst_ni) begin
      cal_enabled = 1'b0;
      valid_floor = ValidReset;
      for (int c = 0; c < NumCh; c++) begin
        ch_lower[c] = '1;
        ch_upper[c] = '0;
      end
      pending_positions.delete();
      frames_checked_o <= 0;
      fail_count_o     = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        frames_checked_o <= frames_checked_o + 1;
        got = {out_mon.position_ch4, out_mon.position_ch3,
               out_mon.position_ch2, out_mon.position_ch1};
        if (pending_positions.size() == 0) begin
          $error("position transaction with no frame pending");
          fail_count_o++;
        end else begin
          want = pending_positions.pop_front();
          for (int c = 0; c < NumCh; c++) begin
            if (got[c] !== want[c]) begin
              $error("position_ch%0d mismatch: expected %0d, actual %0d",
                     c + 1, want[c], got[c]);
              fail_count_o++;
            end
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_CAL_EN:    cal_enabled = cfg_mon.data[0];
          REG_MIN_VALID: valid_floor = cfg_mon.data[MinValidBits-1:0];
          default:       ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_positions.push_back(calibrate_and_normalize(
          {in_mon.width_ch4, in_mon.width_ch3, in_mon.width_ch2, in_mon.width_ch1}));
      end
      if (end_of_test_i && pending_positions.size() != 0) begin
        $error("%0d frames never got their positions", pending_positions.size());
        fail_count_o += pending_positions.size();
        pending_positions.delete();
      end
    end
  end

endmodule

// ===== sim/rc_channel_calibrate_normalize_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_channel_calibrate_normalize_tb
// drives frames of four pulse widths and register writes into the block,
// stalls both sides at random, and lets the checker predict and compare the
// normalized positions; a short directed part is followed by random phases
// over several calibration settings
// ----------------------------------------------------------------------------
module rc_channel_calibrate_normalize_tb;
  import rccn_pkg::*;

  typedef logic [NumCh-1:0][WidthBits-1:0] frame_t;

  // register indexes the block does not decode, writes there are dropped
  localparam logic [CfgIdxBits-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegSpareB = 2'd3;

  localparam int CycleLimit  = 500_000;
  localparam int DrainCycles = 100;
  localparam int IdlePercent = 10;
  localparam int PhaseFrames = 100;
  localparam int NumPhases   = 7;

  logic clk;
  logic rst_n;
  logic quiet;          // no idling on either side while set
  logic end_of_test;
  int   frames_sent;
  int   frames_checked;
  int   fail_count;
  int   cycle_count;

  rccn_cfg_if cfg_if ();
  rccn_in_if  in_if ();
  rccn_out_if out_if ();

  rc_channel_calibrate_normalize dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rc_channel_calibrate_normalize_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_mon          (cfg_if),
    .in_mon           (in_if),
    .out_mon          (out_if),
    .end_of_test_i    (end_of_test),
    .frames_checked_o (frames_checked),
    .fail_count_o     (fail_count)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // position sink: drops ready at random about ten percent of the time unless quiet
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** rc_channel_calibrate_normalize: FAILED **");
      $finish;
    end
  end

  // wait until every frame sent so far has come back as a position transaction
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (frames_checked != frames_sent) @(posedge clk);
  endtask

  // one register write, only once the block is idle
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] value);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // one frame transaction, with a random gap in front of it unless quiet
  task automatic send_frame(input frame_t f);
    if (!quiet && $urandom_range(0, 99) < IdlePercent) begin
      in_if.valid     <= 1'b0;
      in_if.width_ch1 <= WidthBits'($urandom());
      in_if.width_ch2 <= WidthBits'($urandom());
      in_if.width_ch3 <= WidthBits'($urandom());
      in_if.width_ch4 <= WidthBits'($urandom());
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.width_ch1 <= f[0];
    in_if.width_ch2 <= f[1];
    in_if.width_ch3 <= f[2];
    in_if.width_ch4 <= f[3];
    do @(posedge clk); while (!in_if.ready);
    frames_sent++;
  endtask

  // mostly rc-like widths, some right at the validity threshold; wide phases
  // add the full 16-bit range and both extremes
  function automatic logic [WidthBits-1:0] draw_width(logic [MinValidBits-1:0] floor_w,
                                                      bit wide);
    int pick;
    int near;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      near = int'(floor_w) + int'($urandom_range(0, 4)) - 2;
      if (near < 0) near = 0;
      if (near > 65535) near = 65535;
      return WidthBits'(near);
    end
    if (!wide || pick < 70) return WidthBits'($urandom_range(950, 2050));
    if (pick < 92) return WidthBits'($urandom());
    return pick[0] ? '1 : '0;
  endfunction

  // one random phase under one calibration setting
  task automatic run_phase(input bit cal_on, input logic [MinValidBits-1:0] floor_w,
                           input bit wide, input bit no_idle);
    frame_t f;
    if ($urandom_range(0, 1)) begin
      write_reg(REG_CAL_EN, {15'($urandom_range(0, 32767)), cal_on});
      write_reg(REG_MIN_VALID, floor_w);
    end else begin
      write_reg(REG_MIN_VALID, floor_w);
      write_reg(REG_CAL_EN, {15'($urandom_range(0, 32767)), cal_on});
    end
    quiet <= no_idle;
    for (int i = 0; i < PhaseFrames; i++) begin
      for (int c = 0; c < NumCh; c++) f[c] = draw_width(floor_w, wide);
      send_frame(f);
    end
  endtask

  initial begin
    // block inputs known from time zero, the sink's ready from the first edge
    rst_n           = 1'b0;
    quiet           <= 1'b0;
    end_of_test     <= 1'b0;
    cycle_count     <= 0;
    frames_sent     = 0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_CAL_EN;
    cfg_if.data     <= '0;
    in_if.valid     <= 1'b0;
    in_if.width_ch1 <= '0;
    in_if.width_ch2 <= '0;
    in_if.width_ch3 <= '0;
    in_if.width_ch4 <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // reset bounds: empty range everywhere, both input extremes
    send_frame({16'd0, 16'd0, 16'd0, 16'd0});
    send_frame({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});

    // calibration on; upper data bits are junk and must be ignored
    write_reg(REG_CAL_EN, 16'hFFFF);
    // ch1 single point (upper equals lower), ch2 at the low edge of validity,
    // ch3 mid rc, ch4 below threshold so it stays uncalibrated
    send_frame({16'd50, 16'd1500, 16'd101, 16'd1000});
    // ch4 exactly at threshold is still not valid, ch2 reaches full scale
    send_frame({16'd100, 16'd1501, 16'hFFFF, 16'd2000});
    // mid position, widths on the lower bounds, ch4 first valid width
    send_frame({16'd101, 16'd1500, 16'd101, 16'd1500});
    send_frame({16'd102, 16'd1501, 16'hFFFE, 16'd1999});
    send_frame({16'd101, 16'd1500, 16'd32818, 16'd1001});

    // undecoded indexes: nothing may change
    write_reg(RegSpareA, 16'hFFFF);
    write_reg(RegSpareB, 16'h0000);
    send_frame({16'd150, 16'd1501, 16'd40000, 16'd1250});

    // lowest threshold: width 1 becomes a valid bound
    write_reg(REG_MIN_VALID, 16'd0);
    send_frame({16'd1, 16'd1500, 16'd30000, 16'd1750});
    send_frame({16'd0, 16'd1500, 16'd30000, 16'd1750});

    // highest threshold: no width can widen a bound
    write_reg(REG_MIN_VALID, 16'hFFFF);
    send_frame({16'hFFFF, 16'd0, 16'hFFFF, 16'd500});
    send_frame({16'd20000, 16'd1499, 16'd1, 16'd2500});

    // calibration off, bit 0 clear under junk: clamp below and above range
    write_reg(REG_CAL_EN, 16'hFFFE);
    write_reg(REG_MIN_VALID, 16'd100);
    send_frame({16'd0, 16'hFFFF, 16'd0, 16'd0});
    send_frame({16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF});
    send_frame({16'd70, 16'd1500, 16'd12345, 16'd1333});
    send_frame({16'd101, 16'd1502, 16'd101, 16'd999});

    // --- random phases ---
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       run_phase(1'b1, 16'd100, 1'b0, 1'b0);
        1:       run_phase(1'b0, 16'd100, 1'b1, 1'b0);
        // long stretch without idling on either side
        2:       run_phase(1'b1, MinValidBits'($urandom_range(800, 1200)), 1'b0, 1'b1);
        3:       run_phase(1'b0, MinValidBits'($urandom()), 1'b1, 1'b0);
        4:       run_phase(1'b1, 16'hFFFF, 1'b1, 1'b0);
        5:       run_phase(1'b1, 16'd0, 1'b1, 1'b0);
        default: run_phase(1'b0, 16'd100, 1'b1, 1'b0);
      endcase
    end

    // drain, then give a stray late transaction time to show up
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("** rc_channel_calibrate_normalize: PASSED **");
    end else begin
      $display("** rc_channel_calibrate_normalize: FAILED **");
    end
    $finish;
  end

endmodule
